// ===== sv/piecewise_linear_interpolation_table_assert.svh =====
// Assertion macros shared by the checker of the interpolation table.
`ifndef PIECEWISE_LINEAR_INTERPOLATION_TABLE_ASSERT_SVH
`define PIECEWISE_LINEAR_INTERPOLATION_TABLE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define PLIT_ASSERT_IMPL(name, clk, rst, cond, expr, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define PLIT_ASSERT_NEXT(name, clk, rst, cond, expr, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error(msg);

`endif

// ===== sv/plit_pkg.sv =====
// Types, codes and widths shared by the interpolation table modules.
package plit_pkg;

  localparam int DEFAULT_TABLE_DEPTH = 128;
  localparam int DATA_W = 32;
  localparam int DIFF_W = 33;
  localparam int PROD_W = 65;
  localparam int MAG_W  = 41;
  localparam int SUM_W  = 42;

  localparam logic [1:0] FUNC_CLEAR  = 2'd0;
  localparam logic [1:0] FUNC_APPEND = 2'd1;
  localparam logic [1:0] FUNC_QUERY  = 2'd2;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_RANGE = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  // Largest quotient magnitude kept before the final add, 2^40.
  localparam logic [PROD_W-1:0] SAT_LIMIT = 65'h100_0000_0000;

  typedef struct packed {
    logic        [1:0]        func;
    logic signed [DATA_W-1:0] x_value;
    logic signed [DATA_W-1:0] y_value;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] result_y;
    logic        [1:0]        status;
  } out_item_t;

  typedef struct packed {
    logic                     go;
    logic signed [DIFF_W-1:0] dy;
    logic signed [DIFF_W-1:0] dq;
    logic signed [DIFF_W-1:0] dx;
    logic signed [DATA_W-1:0] y1;
  } md_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [DATA_W-1:0] y;
  } md_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_FIRST, ST_LAST, ST_SCAN, ST_PREV, ST_WAIT
  } state_t;

  typedef enum logic [2:0] {
    MD_IDLE, MD_SIGN, MD_MUL, MD_DIV, MD_FINAL
  } md_state_t;

endpackage

// ===== sv/plit_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module plit_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/plit_muldiv.sv =====
// Sequential interpolation arithmetic: y1 + dy * dq / dx with saturation.
module plit_muldiv (
  input  logic              clk,
  input  logic              rst,
  input  plit_pkg::md_req_t req,
  output plit_pkg::md_rsp_t rsp
);
  import plit_pkg::*;

  localparam int STEP_W = $clog2(PROD_W);

  md_state_t state, state_next;

  logic signed [DIFF_W-1:0] dy, dq, dx;
  logic signed [DATA_W-1:0] y1;
  logic                     neg;
  logic [PROD_W-1:0]        mcand, acc;
  logic [DIFF_W-1:0]        mplier, mdx, rem;
  logic [STEP_W-1:0]        step;
  logic                     done;
  logic signed [DATA_W-1:0] y;

  logic [DIFF_W:0]          rs;
  logic                     ge;
  logic [MAG_W-1:0]         mag;
  logic signed [SUM_W-1:0]  sum;
  logic signed [DATA_W-1:0] y_sat;

  assign rsp.done = done;
  assign rsp.y    = y;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= MD_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      MD_IDLE:  if (req.go) state_next = MD_SIGN;
      MD_SIGN:  state_next = MD_MUL;
      MD_MUL:   if (step == STEP_W'(DIFF_W - 1)) state_next = MD_DIV;
      MD_DIV:   if (step == STEP_W'(PROD_W - 1)) state_next = MD_FINAL;
      MD_FINAL: state_next = MD_IDLE;
      default:  state_next = MD_IDLE;
    endcase
  end

  // One restoring step: the next dividend bit joins the remainder.
  assign rs = {rem, acc[PROD_W-1]};
  assign ge = rs >= {1'b0, mdx};

  always_comb begin
    mag = (acc > SAT_LIMIT) ? SAT_LIMIT[MAG_W-1:0] : acc[MAG_W-1:0];
    if (neg) begin
      sum = SUM_W'(y1) - $signed({1'b0, mag});
    end else begin
      sum = SUM_W'(y1) + $signed({1'b0, mag});
    end
    if (sum > SUM_W'(32'sh7FFF_FFFF)) begin
      y_sat = 32'sh7FFF_FFFF;
    end else if (sum < SUM_W'(32'sh8000_0000)) begin
      y_sat = 32'sh8000_0000;
    end else begin
      y_sat = sum[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == MD_FINAL);
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      MD_IDLE: begin
        if (req.go) begin
          dy <= req.dy;
          dq <= req.dq;
          dx <= req.dx;
          y1 <= req.y1;
        end
      end
      MD_SIGN: begin
        mcand  <= PROD_W'(dy[DIFF_W-1] ? -dy : dy);
        mplier <= dq[DIFF_W-1] ? -dq : dq;
        mdx    <= dx[DIFF_W-1] ? -dx : dx;
        neg    <= dy[DIFF_W-1] ^ dq[DIFF_W-1] ^ dx[DIFF_W-1];
        acc    <= '0;
        rem    <= '0;
        step   <= '0;
      end
      MD_MUL: begin
        if (mplier[0]) begin
          acc <= acc + mcand;
        end
        mcand  <= {mcand[PROD_W-2:0], 1'b0};
        mplier <= {1'b0, mplier[DIFF_W-1:1]};
        step   <= (step == STEP_W'(DIFF_W - 1)) ? '0 : step + 1'b1;
      end
      MD_DIV: begin
        rem  <= ge ? DIFF_W'(rs - {1'b0, mdx}) : rs[DIFF_W-1:0];
        acc  <= {acc[PROD_W-2:0], ge};
        step <= step + 1'b1;
      end
      MD_FINAL: begin
        y <= y_sat;
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== sv/piecewise_linear_interpolation_table.sv =====
// Top level of the piecewise linear interpolation table.
//
//   channel   ports                    handshake
//   input     item (func, x, y)        taken when start is high and busy is low
//   result    result (result_y,status) valid for one cycle while done is high
//
// Clear and append give no result. A query reads the first and last
// points, scans x one entry a cycle through the x memory port, reads the
// left point, then runs the arithmetic unit: 33 multiply steps and 65
// divide steps, the result showing in the same cycle that busy falls.
// Reset is synchronous and empties the table at once.
// The receiver cannot stall; busy holds off new items.
module piecewise_linear_interpolation_table #(
  parameter int TABLE_DEPTH = plit_pkg::DEFAULT_TABLE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  plit_pkg::in_item_t  item,
  output logic                done,
  output plit_pkg::out_item_t result
);
  import plit_pkg::*;

  localparam int AW    = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  state_t state, state_next;

  logic [CNT_W-1:0]         count;
  logic [AW-1:0]            idx;
  logic signed [DATA_W-1:0] xq, y0, x2, y2;

  logic                     we;
  logic [AW-1:0]            raddr;
  logic signed [DATA_W-1:0] rdata_x, rdata_y;

  logic                     done_next;
  out_item_t                res_next;
  md_req_t                  req;
  md_rsp_t                  rsp;
  logic                     accept;
  logic                     scan_more;

  plit_ram #(.WIDTH(DATA_W), .DEPTH(TABLE_DEPTH)) u_ram_x (
    .clk   (clk),
    .we    (we),
    .waddr (count[AW-1:0]),
    .wdata (item.x_value),
    .raddr (raddr),
    .rdata (rdata_x)
  );

  plit_ram #(.WIDTH(DATA_W), .DEPTH(TABLE_DEPTH)) u_ram_y (
    .clk   (clk),
    .we    (we),
    .waddr (count[AW-1:0]),
    .wdata (item.y_value),
    .raddr (raddr),
    .rdata (rdata_y)
  );

  plit_muldiv u_muldiv (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  assign busy      = (state != ST_IDLE);
  assign accept    = start && !busy;
  assign we        = accept && (item.func == FUNC_APPEND) &&
                     (count < CNT_W'(TABLE_DEPTH));
  assign scan_more = (CNT_W'(idx) < count - 1'b1) && (xq > rdata_x);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
      if (accept && item.func == FUNC_CLEAR) begin
        count <= '0;
      end else if (we) begin
        count <= count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (done_next) begin
      result <= res_next;
    end
    unique case (state)
      ST_IDLE:  xq <= item.x_value;
      ST_FIRST: y0 <= rdata_y;
      ST_LAST:  idx <= AW'(1);
      ST_SCAN: begin
        if (scan_more) begin
          idx <= idx + 1'b1;
        end else begin
          x2 <= rdata_x;
          y2 <= rdata_y;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_next = state;
    raddr      = '0;
    done_next  = 1'b0;
    res_next   = '{result_y: '0, status: STATUS_OK};
    req        = '{go: 1'b0, dy: '0, dq: '0, dx: '0, y1: rdata_y};
    unique case (state)
      ST_IDLE: begin
        if (accept && item.func == FUNC_QUERY) begin
          if (count == '0) begin
            done_next       = 1'b1;
            res_next.status = STATUS_EMPTY;
          end else begin
            state_next = ST_FIRST;
          end
        end
      end
      ST_FIRST: begin
        if (xq < rdata_x) begin
          done_next       = 1'b1;
          res_next.status = STATUS_RANGE;
          state_next      = ST_IDLE;
        end else begin
          raddr      = AW'(count - 1'b1);
          state_next = ST_LAST;
        end
      end
      ST_LAST: begin
        if (xq > rdata_x) begin
          done_next       = 1'b1;
          res_next.status = STATUS_RANGE;
          state_next      = ST_IDLE;
        end else if (count == CNT_W'(1)) begin
          done_next         = 1'b1;
          res_next.result_y = y0;
          state_next        = ST_IDLE;
        end else begin
          raddr      = AW'(1);
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_more) begin
          raddr = idx + 1'b1;
        end else begin
          raddr      = idx - 1'b1;
          state_next = ST_PREV;
        end
      end
      ST_PREV: begin
        // A zero-width segment answers the right point's y directly.
        if (x2 == rdata_x) begin
          done_next         = 1'b1;
          res_next.result_y = y2;
          state_next        = ST_IDLE;
        end else begin
          req.go     = 1'b1;
          req.dy     = {y2[DATA_W-1], y2} - {rdata_y[DATA_W-1], rdata_y};
          req.dq     = {xq[DATA_W-1], xq} - {rdata_x[DATA_W-1], rdata_x};
          req.dx     = {x2[DATA_W-1], x2} - {rdata_x[DATA_W-1], rdata_x};
          state_next = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (rsp.done) begin
          done_next         = 1'b1;
          res_next.result_y = rsp.y;
          state_next        = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ===== sv/plit_checker.sv =====
// Port-level checks of the interpolation table, bound to the top level.
`include "piecewise_linear_interpolation_table_assert.svh"

module plit_checker (
  input logic                clk,
  input logic                rst,
  input logic                start,
  input logic                busy,
  input plit_pkg::in_item_t  item,
  input logic                done,
  input plit_pkg::out_item_t result
);
  import plit_pkg::*;

  `PLIT_ASSERT_IMPL(a_done_idle, clk, rst, done, !busy, "result shown while busy")
  `PLIT_ASSERT_NEXT(a_query_progress, clk, rst, start && !busy && item.func == FUNC_QUERY, busy || done, "query neither started nor answered")
  `PLIT_ASSERT_NEXT(a_no_spurious, clk, rst, !busy && !(start && item.func == FUNC_QUERY), !done, "result without a query")
  `PLIT_ASSERT_IMPL(a_zero_on_error, clk, rst, done && result.status != STATUS_OK, result.result_y == '0 && (result.status == STATUS_RANGE || result.status == STATUS_EMPTY), "bad error result")

endmodule

bind piecewise_linear_interpolation_table plit_checker u_plit_checker (.*);
